// File: rtl/lcs_pkg.sv
// Shared constants and types for the LCS length unit.
package lcs_pkg;

   localparam int MAX_LEN = 64;
   localparam int SCORE_W = $clog2(MAX_LEN + 1);
   localparam int COUNT_W = $clog2(MAX_LEN + 1);
   localparam int SYM_W   = 8;

   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   // Query byte travelling along the cell row with its running scores.
   typedef struct packed {
      logic               active;
      logic               last;
      logic [SYM_W-1:0]   sym;
      logic [SCORE_W-1:0] diag;
      logic [SCORE_W-1:0] left;
   } token_type;

   // Reference store control broadcast to every cell.
   typedef struct packed {
      logic               append;
      logic               clear;
      logic [COUNT_W-1:0] count;
      logic [SYM_W-1:0]   sym;
   } ctl_type;

endpackage

// File: rtl/lcs_cell.sv
// One reference position: stored byte, its score and the token stage to the next cell.
module lcs_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lcs_pkg::COUNT_W-1:0] cell_index,
   input  lcs_pkg::ctl_type            ctl,
   input  lcs_pkg::token_type          tok_in,
   output lcs_pkg::token_type          tok_out
);

   logic [lcs_pkg::SYM_W-1:0]   ref_ff;
   logic [lcs_pkg::SCORE_W-1:0] score_ff;
   logic [lcs_pkg::SCORE_W-1:0] score_in;
   lcs_pkg::token_type          tok_ff;
   lcs_pkg::token_type          tok_in_next;
   logic                        in_use;
   logic                        append_here;
   logic [lcs_pkg::SCORE_W-1:0] new_score;

   assign in_use      = cell_index < ctl.count;
   assign append_here = ctl.append && (cell_index == ctl.count);

   always_comb begin
      if (ref_ff == tok_in.sym) begin
         new_score = tok_in.diag + lcs_pkg::SCORE_W'(1);
      end else if (score_ff > tok_in.left) begin
         new_score = score_ff;
      end else begin
         new_score = tok_in.left;
      end
   end

   always_comb begin
      score_in    = score_ff;
      tok_in_next = tok_in;
      if (ctl.clear || append_here) begin
         score_in = '0;
      end else if (tok_in.active && in_use) begin
         // The last query byte leaves the row cleared behind it.
         score_in         = tok_in.last ? '0 : new_score;
         tok_in_next.diag = score_ff;
         tok_in_next.left = new_score;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff      <= '0;
         tok_ff.active <= 1'b0;
      end else begin
         score_ff      <= score_in;
         tok_ff.active <= tok_in.active;
      end
      if (append_here) begin
         ref_ff <= ctl.sym;
      end
      if (tok_in.active) begin
         tok_ff.last <= tok_in_next.last;
         tok_ff.sym  <= tok_in_next.sym;
         tok_ff.diag <= tok_in_next.diag;
         tok_ff.left <= tok_in_next.left;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: rtl/lcs_cell_row.sv
// Chain of reference cells that a query token sweeps through, one cell per cycle.
module lcs_cell_row (
   input  logic               clock,
   input  logic               reset,
   input  lcs_pkg::ctl_type   ctl,
   input  lcs_pkg::token_type tok_in,
   output lcs_pkg::token_type tok_out
);

   lcs_pkg::token_type tok_chain [lcs_pkg::MAX_LEN+1];

   assign tok_chain[0] = tok_in;

   for (genvar j = 0; j < lcs_pkg::MAX_LEN; j++) begin : g_cell
      lcs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (lcs_pkg::COUNT_W'(j)),
         .ctl        (ctl),
         .tok_in     (tok_chain[j]),
         .tok_out    (tok_chain[j+1])
      );
   end

   assign tok_out = tok_chain[lcs_pkg::MAX_LEN];

endmodule

// File: rtl/lcs_length_unit.sv
// LCS length unit: reference store control, query injection and result register.
//
// Input channel req_: tuser carries the mode, tdata the byte, tlast marks the
// final query byte. Mode 0 appends a reference byte, mode 2 clears the
// reference and the score row, mode 1 sends a query byte through the row.
// Appends and clears are taken back to back. A query byte is
// carried by a token that walks the chain of MAX_LEN cells, one cell per
// cycle, so req_tready stays low after a query transaction until its token
// has left the chain; no new byte is taken while a query byte is in the
// chain, so the wait is set by the length of the cell chain.
// Result channel rsp_: a query byte with tlast yields one transaction that
// is registered once its token leaves the chain and carries the LCS length
// and the overflow flag. The result waits in an output register while
// rsp_tready is low; appends, clears and query bytes are still taken
// meanwhile, and a later final result is held at the end of the chain until
// the output register frees, req_tready staying low until then.
// Reset clears the reference count, overflow flag, score row and all valid
// flags; it takes effect at the next clock edge and needs no clearing pass.
module lcs_length_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] mode
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [6:0] lcs_length, [7] ref_overflow
);

   logic [lcs_pkg::COUNT_W-1:0] count_ff,  count_in;
   logic                        ovf_ff,    ovf_in;
   logic                        busy_ff,   busy_in;
   logic                        pend_ff,   pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_data_ff,  rsp_data_in;
   lcs_pkg::token_type          inj_ff,    inj_in;
   lcs_pkg::token_type          row_out;
   lcs_pkg::ctl_type            ctl;
   logic                        accept;
   logic                        full;
   logic                        slot_free;
   logic                        deliver;
   logic                        exit_last;

   assign accept = req_tvalid && req_tready;
   assign full   = count_ff == lcs_pkg::COUNT_W'(lcs_pkg::MAX_LEN);

   assign ctl.append = accept && (req_tuser == lcs_pkg::MODE_APPEND) && !full;
   assign ctl.clear  = accept && (req_tuser == lcs_pkg::MODE_CLEAR);
   assign ctl.count  = count_ff;
   assign ctl.sym    = req_tdata;

   always_comb begin
      inj_in.active = accept && (req_tuser == lcs_pkg::MODE_QUERY);
      inj_in.last   = req_tlast;
      inj_in.sym    = req_tdata;
      inj_in.diag   = '0;
      inj_in.left   = '0;
   end

   lcs_cell_row u_row (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .tok_in  (inj_ff),
      .tok_out (row_out)
   );

   // The chain end keeps its last token data, so a stalled result is read from there.
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign exit_last = row_out.active && row_out.last;
   assign deliver   = (exit_last || pend_ff) && slot_free;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (ctl.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (ctl.append) begin
         count_in = count_ff + lcs_pkg::COUNT_W'(1);
      end else if (accept && (req_tuser == lcs_pkg::MODE_APPEND)) begin
         ovf_in = 1'b1;
      end

      busy_in = busy_ff;
      if (inj_in.active) begin
         busy_in = 1'b1;
      end else if ((row_out.active && !row_out.last) || deliver) begin
         busy_in = 1'b0;
      end

      pend_in = pend_ff;
      if (deliver) begin
         pend_in = 1'b0;
      end else if (exit_last) begin
         pend_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (deliver) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {ovf_ff, row_out.left};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         busy_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         inj_ff.active <= 1'b0;
      end else begin
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         busy_ff       <= busy_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         inj_ff.active <= inj_in.active;
      end
      rsp_data_ff <= rsp_data_in;
      inj_ff.last <= inj_in.last;
      inj_ff.sym  <= inj_in.sym;
      inj_ff.diag <= inj_in.diag;
      inj_ff.left <= inj_in.left;
   end

   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/lcs_chk.sv
// Port-level checker for the LCS length unit and its bind to the top level.
module lcs_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [1:0] req_tuser,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A result held back by the receiver keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No subsequence is longer than the reference store.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] <= 7'(lcs_pkg::MAX_LEN))
      else $error("lcs length beyond store capacity");

   // A query byte occupies the cell chain, so the input closes after it.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == lcs_pkg::MODE_QUERY) |=> !req_tready)
      else $error("input open during a query sweep");

   // No result survives reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A result needs a final query byte to have gone through the chain first.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == lcs_pkg::MODE_QUERY) && req_tlast
      && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared before the sweep finished");

endmodule

bind lcs_length_unit lcs_chk u_lcs_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
